>>> rtl/srlb_pkg.sv
// shared types, constants and arithmetic helpers of the speed reference lock blender
package srlb_pkg;

  // mode codes
  localparam logic [2:0] MODE_NO_FORCE = 3'd0;
  localparam logic [2:0] MODE_SPIN     = 3'd1;
  localparam logic [2:0] MODE_LOW      = 3'd2;
  localparam logic [2:0] MODE_HIGH     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_SPEED_DEADBAND     = 3'd0;
  localparam logic [2:0] REG_LOCK_ENTER_SPEED   = 3'd1;
  localparam logic [2:0] REG_LOCK_EXIT_SPEED    = 3'd2;
  localparam logic [2:0] REG_LOCK_ENTER_COMMAND = 3'd3;
  localparam logic [2:0] REG_LOCK_EXIT_COMMAND  = 3'd4;
  localparam logic [2:0] REG_MIN_DWELL_TICKS    = 3'd5;
  localparam logic [2:0] REG_BLEND_RISE_STEP    = 3'd6;
  localparam logic [2:0] REG_BLEND_FALL_STEP    = 3'd7;

  // fixed-point constants
  localparam logic [12:0]        ALPHA_ONE  = 13'd4096;
  localparam logic [12:0]        ALPHA_SNAP = 13'd82;
  localparam logic signed [15:0] GAIN_Q12   = 16'sd8602;
  localparam logic [24:0]        PI_Q16     = 25'd205887;
  localparam int                 TWO_PI_Q16 = 411774;
  // largest rounded multiple of pi that a 24-bit yaw magnitude can reach
  localparam int                 YAW_TERMS  = 41;
  localparam logic signed [16:0] STEP_LOW   = 17'sd41;
  localparam logic signed [16:0] STEP_MID   = 17'sd25;
  localparam logic signed [16:0] STEP_HIGH  = 17'sd12;

  typedef struct packed {
    logic [2:0]         mode;
    logic               mode_valid;
    logic               run_enable;
    logic               link_ok;
    logic signed [15:0] speed_command;
    logic signed [23:0] yaw_command;
    logic signed [31:0] measured_position;
    logic signed [15:0] measured_speed;
    logic [31:0]        tick_now;
  } in_item_t;

  typedef struct packed {
    logic               reference_valid;
    logic signed [31:0] position_reference;
    logic signed [15:0] speed_reference;
    logic               speed_reference_valid;
    logic [12:0]        blend_factor;
    logic               lock_requested;
  } out_item_t;

  typedef struct packed {
    logic [11:0] speed_deadband;
    logic [14:0] lock_enter_speed;
    logic [14:0] lock_exit_speed;
    logic [14:0] lock_enter_command;
    logic [14:0] lock_exit_command;
    logic [15:0] min_dwell_ticks;
    logic [12:0] blend_rise_step;
    logic [12:0] blend_fall_step;
  } cfg_regs_t;

  // input-side precompute handed to the state stage
  typedef struct packed {
    logic [2:0]         mode;
    logic               mode_valid;
    logic               permitted;
    logic               link_ok;
    logic signed [31:0] position;
    logic signed [15:0] speed;
    logic [31:0]        tick;
    logic [15:0]        speed_mag;
    logic [15:0]        command_abs;
    logic signed [15:0] target;
  } front_t;

  // state stage result handed to the blend multipliers
  typedef struct packed {
    logic               ref_valid;
    logic               blend_on;
    logic               speed_valid;
    logic               lock_flag;
    logic [12:0]        alpha;
    logic signed [31:0] lock_ref;
    logic signed [31:0] position;
    logic signed [15:0] speed;
  } stage_t;

  // scale down by 2^12, rounding half away from zero
  function automatic logic signed [47:0] round_shift12(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r = (mag + 48'd2048) >> 12;
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // parity of round(yaw / pi) from 2*|yaw| + pi against multiples of 2*pi
  function automatic logic yaw_odd(input logic [24:0] v);
    logic odd;
    odd = 1'b0;
    for (int j = 1; j <= YAW_TERMS; j++) begin
      odd = odd ^ (v >= 25'(j * TWO_PI_Q16));
    end
    return odd;
  endfunction

endpackage

>>> rtl/srlb_regs.sv
// configuration register file of the speed reference lock blender
module srlb_regs import srlb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_regs_t   cfg
);

  assign cfg_ready = 1'b1;

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_deadband     <= 12'd410;
      cfg.lock_enter_speed   <= 15'd1229;
      cfg.lock_exit_speed    <= 15'd2253;
      cfg.lock_enter_command <= 15'd328;
      cfg.lock_exit_command  <= 15'd492;
      cfg.min_dwell_ticks    <= 16'd100;
      cfg.blend_rise_step    <= 13'd61;
      cfg.blend_fall_step    <= 13'd74;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_DEADBAND:     cfg.speed_deadband     <= cfg_data[11:0];
        REG_LOCK_ENTER_SPEED:   cfg.lock_enter_speed   <= cfg_data[14:0];
        REG_LOCK_EXIT_SPEED:    cfg.lock_exit_speed    <= cfg_data[14:0];
        REG_LOCK_ENTER_COMMAND: cfg.lock_enter_command <= cfg_data[14:0];
        REG_LOCK_EXIT_COMMAND:  cfg.lock_exit_command  <= cfg_data[14:0];
        REG_MIN_DWELL_TICKS:    cfg.min_dwell_ticks    <= cfg_data[15:0];
        REG_BLEND_RISE_STEP:    cfg.blend_rise_step    <= cfg_data[12:0];
        REG_BLEND_FALL_STEP:    cfg.blend_fall_step    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/srlb_front.sv
// input register and stateless precompute: magnitudes, gained command, yaw sign flip
module srlb_front import srlb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      front_valid,
  input  logic      front_ready,
  output front_t    front
);

  logic               held_valid;
  in_item_t           held;
  logic               ready;
  logic [23:0]        yaw_abs;
  logic [24:0]        yaw_term;
  logic signed [47:0] gain_prod;
  logic signed [15:0] target;
  logic [15:0]        command_mag;

  assign ready      = !held_valid || front_ready;
  assign item_stall = !ready;
  assign front_valid = held_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && item_valid) begin
      held <= item;
    end
  end

  // effective mode, permission and magnitudes
  always_comb begin
    front.mode        = held.mode_valid ? held.mode : MODE_NO_FORCE;
    front.mode_valid  = held.mode_valid;
    front.permitted   = held.mode_valid && (held.run_enable || held.mode == MODE_NO_FORCE);
    front.link_ok     = held.link_ok;
    front.position    = held.measured_position;
    front.speed       = held.measured_speed;
    front.tick        = held.tick_now;
    front.speed_mag   = held.measured_speed[15] ? 16'(-held.measured_speed)
                                                : 16'(held.measured_speed);
    front.command_abs = command_mag;
    front.target      = target;
  end

  // deadband, gain of 2.1, then sign flip at odd multiples of pi
  always_comb begin
    command_mag = held.speed_command[15] ? 16'(-held.speed_command)
                                         : 16'(held.speed_command);
    yaw_abs   = held.yaw_command[23] ? 24'(-held.yaw_command) : 24'(held.yaw_command);
    yaw_term  = {yaw_abs, 1'b0} + PI_Q16;
    gain_prod = 48'(held.speed_command) * 48'(GAIN_Q12);
    target    = 16'sd0;
    if (command_mag > {4'd0, cfg.speed_deadband}) begin
      target = sat16(round_shift12(gain_prod));
    end
    if (yaw_odd(yaw_term)) begin
      target = (target == -16'sd32768) ? 16'sd32767 : -target;
    end
  end

endmodule

>>> rtl/srlb_core.sv
// lock state, dwell hysteresis, blend ramp and speed slew, one item per cycle while the stage register is not stalled
module srlb_core import srlb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      front_valid,
  output logic      front_ready,
  input  front_t    front,
  output logic      stage_valid,
  input  logic      stage_ready,
  output stage_t    stage
);

  logic [2:0]         previous_mode;
  logic               lock_flag;
  logic [12:0]        blend_alpha;
  logic signed [31:0] lock_reference;
  logic [31:0]        last_switch_tick;
  logic signed [15:0] slewed_speed;

  logic [2:0]         previous_mode_next;
  logic               lock_flag_next;
  logic [12:0]        blend_alpha_next;
  logic signed [31:0] lock_reference_next;
  logic [31:0]        last_switch_tick_next;
  logic signed [15:0] slewed_speed_next;

  stage_t             stage_next;
  logic               take;
  logic               req_lock;
  logic               req_unlock;
  logic               dwell_ok;
  logic [31:0]        elapsed;
  logic [13:0]        alpha_sum;
  logic signed [16:0] step;
  logic signed [16:0] slew_sum;

  assign front_ready = !stage_valid || stage_ready;
  assign take        = front_valid && front_ready;

  assign req_lock   = front.speed_mag < {1'b0, cfg.lock_enter_speed} &&
                      front.command_abs < {1'b0, cfg.lock_enter_command};
  assign req_unlock = front.speed_mag > {1'b0, cfg.lock_exit_speed} ||
                      front.command_abs > {1'b0, cfg.lock_exit_command};

  // slew step per leg height
  always_comb begin
    case (front.mode)
      MODE_LOW:  step = STEP_LOW;
      MODE_HIGH: step = STEP_HIGH;
      default:   step = STEP_MID;
    endcase
  end

  // next state and stage contents for the item in the input register
  always_comb begin
    previous_mode_next    = previous_mode;
    lock_flag_next        = lock_flag;
    blend_alpha_next      = blend_alpha;
    lock_reference_next   = lock_reference;
    last_switch_tick_next = last_switch_tick;
    slewed_speed_next     = slewed_speed;
    stage_next            = '0;
    elapsed               = 32'd0;
    dwell_ok              = 1'b0;
    alpha_sum             = 14'd0;
    slew_sum              = 17'sd0;

    // a mode change restarts the lock state even when no result is permitted
    if (front.mode_valid && front.mode != previous_mode) begin
      lock_flag_next        = 1'b0;
      blend_alpha_next      = 13'd0;
      lock_reference_next   = front.position;
      last_switch_tick_next = front.tick;
      slewed_speed_next     = front.speed;
      previous_mode_next    = front.mode;
    end

    if (front.permitted) begin
      stage_next.ref_valid   = 1'b1;
      stage_next.speed_valid = 1'b1;
      stage_next.position    = front.position;
      if (front.link_ok) begin
        // lock entry and exit with dwell
        elapsed  = front.tick - last_switch_tick_next;
        dwell_ok = elapsed >= {16'd0, cfg.min_dwell_ticks};
        if (front.mode == MODE_NO_FORCE || front.mode == MODE_SPIN) begin
          lock_flag_next = 1'b0;
        end else if (!lock_flag_next && req_lock && dwell_ok) begin
          lock_flag_next        = 1'b1;
          lock_reference_next   = front.position;
          last_switch_tick_next = front.tick;
        end else if (lock_flag_next && req_unlock && dwell_ok) begin
          lock_flag_next        = 1'b0;
          last_switch_tick_next = front.tick;
        end

        // blend ramp with clamp
        if (lock_flag_next) begin
          alpha_sum        = {1'b0, blend_alpha_next} + {1'b0, cfg.blend_rise_step};
          blend_alpha_next = (alpha_sum > {1'b0, ALPHA_ONE}) ? ALPHA_ONE : alpha_sum[12:0];
        end else begin
          blend_alpha_next = (blend_alpha_next > cfg.blend_fall_step)
                           ? blend_alpha_next - cfg.blend_fall_step : 13'd0;
        end
        if (blend_alpha_next < ALPHA_SNAP) begin
          lock_reference_next = front.position;
        end

        case (front.mode)
          MODE_NO_FORCE: begin
            slewed_speed_next = front.speed;
            stage_next.speed  = front.speed;
          end
          MODE_SPIN: begin
            slewed_speed_next      = front.speed;
            stage_next.speed       = 16'sd0;
            stage_next.speed_valid = 1'b0;
          end
          default: begin
            // slew toward the target, never past it
            if (slewed_speed_next < front.target) begin
              slew_sum          = 17'(slewed_speed_next) + step;
              slewed_speed_next = (slew_sum > 17'(front.target)) ? front.target
                                                                 : slew_sum[15:0];
            end else if (slewed_speed_next > front.target) begin
              slew_sum          = 17'(slewed_speed_next) - step;
              slewed_speed_next = (slew_sum < 17'(front.target)) ? front.target
                                                                 : slew_sum[15:0];
            end
            stage_next.blend_on = 1'b1;
            stage_next.speed    = slewed_speed_next;
          end
        endcase
      end else begin
        // link down drops the lock and zeroes the command
        lock_flag_next      = 1'b0;
        blend_alpha_next    = 13'd0;
        lock_reference_next = front.position;
        slewed_speed_next   = 16'sd0;
        stage_next.speed    = 16'sd0;
      end
      stage_next.lock_flag = lock_flag_next;
      stage_next.alpha     = blend_alpha_next;
      stage_next.lock_ref  = lock_reference_next;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mode    <= MODE_NO_FORCE;
      lock_flag        <= 1'b0;
      blend_alpha      <= 13'd0;
      lock_reference   <= 32'sd0;
      last_switch_tick <= 32'd0;
      slewed_speed     <= 16'sd0;
    end else if (take) begin
      previous_mode    <= previous_mode_next;
      lock_flag        <= lock_flag_next;
      blend_alpha      <= blend_alpha_next;
      lock_reference   <= lock_reference_next;
      last_switch_tick <= last_switch_tick_next;
      slewed_speed     <= slewed_speed_next;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (front_ready) begin
      stage_valid <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= stage_next;
    end
  end

endmodule

>>> rtl/srlb_blend.sv
// blend multipliers and result register
module srlb_blend import srlb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      stage_valid,
  output logic      stage_ready,
  input  stage_t    stage,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic [12:0]        inv;
  logic signed [47:0] pos_hold;
  logic signed [47:0] pos_live;
  logic signed [47:0] pos_round;
  logic signed [47:0] spd_prod;
  out_item_t          result_next;

  assign stage_ready = !result_valid || !result_stall;

  // alpha * lock point + (1 - alpha) * measured, and (1 - alpha) * slewed speed
  always_comb begin
    inv       = ALPHA_ONE - stage.alpha;
    pos_hold  = $signed({35'd0, stage.alpha}) * 48'(stage.lock_ref);
    pos_live  = $signed({35'd0, inv}) * 48'(stage.position);
    pos_round = round_shift12(pos_hold + pos_live);
    spd_prod  = $signed({35'd0, inv}) * 48'(stage.speed);

    result_next.reference_valid       = stage.ref_valid;
    result_next.speed_reference_valid = stage.speed_valid;
    result_next.blend_factor          = stage.alpha;
    result_next.lock_requested        = stage.lock_flag;
    if (stage.blend_on) begin
      result_next.position_reference = pos_round[31:0];
      result_next.speed_reference    = sat16(round_shift12(spd_prod));
    end else begin
      result_next.position_reference = stage.position;
      result_next.speed_reference    = stage.speed;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_ready) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && stage_valid) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/speed_reference_lock_blender.sv
// top level of the speed reference lock blender
//
//   channel | direction | handshake             | payload
//   item    | in        | item_valid/item_stall | in_item_t
//   result  | out       | result_valid/result_stall | out_item_t
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; after its item is accepted,
// a result moves through the input register, the lock state stage and the blend multiply
// register, which is the result register
// the lock state updates as each item is taken, so items follow back to back
// reset clears the pipeline valids, the lock state and loads register defaults
// result_stall holds the result; the stages behind it keep filling and
// item_stall rises only once all three stages hold an item
// cfg_ready is always high
module speed_reference_lock_blender import srlb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  logic      front_valid;
  logic      front_ready;
  front_t    front;
  logic      stage_valid;
  logic      stage_ready;
  stage_t    stage;

  // configuration registers
  srlb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register and precompute
  srlb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .front_valid (front_valid),
    .front_ready (front_ready),
    .front       (front)
  );

  // lock state stage
  srlb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .front_valid (front_valid),
    .front_ready (front_ready),
    .front       (front),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  // blend and result register
  srlb_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_ready  (stage_ready),
    .stage        (stage),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/srlb_checker.sv
// port-level assertions of the speed reference lock blender and their bind
module srlb_checker import srlb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a refused item carries all-zero fields
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.reference_valid |-> result == '0)
    else $error("refused item has nonzero fields");

  // blend factor stays within unity
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.blend_factor <= ALPHA_ONE)
    else $error("blend factor above unity");

  // a result without a valid speed reference, as spin mode gives, has a zero speed reference
  a_spin_speed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.speed_reference_valid |-> result.speed_reference == 16'sd0)
    else $error("speed reference present without valid");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind speed_reference_lock_blender srlb_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> tb/speed_reference_lock_blender_test.sv
// self-checking testbench for the speed reference lock blender
module speed_reference_lock_blender_test import srlb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // modes the package leaves unnamed
  localparam logic [2:0] MODE_MID      = 3'd3;
  localparam logic [2:0] MODE_RETRACT1 = 3'd5;
  localparam logic [2:0] MODE_EXTEND   = 3'd6;
  localparam logic [2:0] MODE_RETRACT2 = 3'd7;

  // fixed-point constants of the blend math
  localparam int    BLEND_FULL  = 4096;
  localparam int    BLEND_SNAP  = 82;
  localparam longint STICK_GAIN = 8602;
  localparam longint YAW_PI     = 205887;
  localparam int    SLEW_LOW    = 41;
  localparam int    SLEW_MID    = 25;
  localparam int    SLEW_HIGH   = 12;

  // run control
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  speed_reference_lock_blender u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow of the configuration registers, reset defaults
  cfg_regs_t settings = cfg_regs_t'{12'd410, 15'd1229, 15'd2253, 15'd328, 15'd492,
                                    16'd100, 13'd61, 13'd74};

  // shadow of the lock and slew state
  logic [2:0]  last_mode   = MODE_NO_FORCE;
  bit          lock_on     = 1'b0;
  int          alpha       = 0;
  int          held_pos    = 0;
  logic [31:0] switch_tick = '0;
  int          slew        = 0;

  out_item_t expected_refs[$];
  int        error_count = 0;
  int        cycle_count = 0;

  // traffic shaping
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  // random sequence context
  logic [2:0]  seq_mode = MODE_LOW;
  bit          calm     = 1'b1;
  logic [31:0] cur_tick = 32'd5000;
  int          cur_pos  = 0;

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // scale down by 2^12, rounding half away from zero
  function automatic longint round_q12(longint v);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + 2048) >>> 12;
    return (v < 0) ? -r : r;
  endfunction

  function automatic int clamp_s16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // expected references for one tick, advancing the shadow state
  function automatic out_item_t predict_reference(in_item_t it);
    out_item_t   o;
    logic [2:0]  m;
    logic [31:0] elapsed;
    int          cmd, yaw, pos, spd, sabs, cabs, tgt, slew_step_size, inv;
    longint      yabs, k;
    bit          want_lock, want_unlock, dwell_met;
    o = '0;
    m = it.mode_valid ? it.mode : MODE_NO_FORCE;
    cmd = int'(it.speed_command);
    yaw = int'(it.yaw_command);
    pos = int'(it.measured_position);
    spd = int'(it.measured_speed);

    // mode change clears the lock point even if not permitted
    if (it.mode_valid && m != last_mode) begin
      lock_on = 1'b0;
      alpha = 0;
      held_pos = pos;
      switch_tick = it.tick_now;
      slew = spd;
      last_mode = m;
    end
    if (!(it.mode_valid && (it.run_enable || m == MODE_NO_FORCE))) return o;

    o.reference_valid = 1'b1;
    o.speed_reference_valid = 1'b1;
    if (!it.link_ok) begin
      lock_on = 1'b0;
      alpha = 0;
      held_pos = pos;
      slew = 0;
      o.position_reference = pos;
      o.speed_reference = '0;
    end else begin
      sabs = (spd < 0) ? -spd : spd;
      cabs = (cmd < 0) ? -cmd : cmd;

      // lock hysteresis with dwell
      if (m == MODE_NO_FORCE || m == MODE_SPIN) begin
        lock_on = 1'b0;
      end else begin
        want_lock = sabs < int'(settings.lock_enter_speed) &&
                    cabs < int'(settings.lock_enter_command);
        want_unlock = sabs > int'(settings.lock_exit_speed) ||
                      cabs > int'(settings.lock_exit_command);
        elapsed = it.tick_now - switch_tick;
        dwell_met = elapsed >= {16'd0, settings.min_dwell_ticks};
        if (!lock_on && want_lock && dwell_met) begin
          lock_on = 1'b1;
          held_pos = pos;
          switch_tick = it.tick_now;
        end else if (lock_on && want_unlock && dwell_met) begin
          lock_on = 1'b0;
          switch_tick = it.tick_now;
        end
      end

      // blend ramp
      if (lock_on) begin
        alpha = alpha + int'(settings.blend_rise_step);
        if (alpha > BLEND_FULL) alpha = BLEND_FULL;
      end else begin
        alpha = (alpha > int'(settings.blend_fall_step)) ?
                alpha - int'(settings.blend_fall_step) : 0;
      end
      if (alpha < BLEND_SNAP) held_pos = pos;

      if (m == MODE_NO_FORCE) begin
        slew = spd;
        o.position_reference = pos;
        o.speed_reference = 16'(spd);
      end else if (m == MODE_SPIN) begin
        slew = spd;
        o.position_reference = pos;
        o.speed_reference = '0;
        o.speed_reference_valid = 1'b0;
      end else begin
        slew_step_size = (m == MODE_LOW) ? SLEW_LOW : (m == MODE_HIGH) ? SLEW_HIGH : SLEW_MID;
        yabs = longint'((yaw < 0) ? -yaw : yaw);
        k = (2 * yabs + YAW_PI) / (2 * YAW_PI);
        inv = BLEND_FULL - alpha;
        tgt = 0;
        if (cabs > int'(settings.speed_deadband)) tgt = clamp_s16(round_q12(cmd * STICK_GAIN));
        // odd multiple of pi turns the command around
        if (k[0]) tgt = clamp_s16(-longint'(tgt));
        if (slew < tgt) begin
          slew = slew + slew_step_size;
          if (slew > tgt) slew = tgt;
        end else if (slew > tgt) begin
          slew = slew - slew_step_size;
          if (slew < tgt) slew = tgt;
        end
        o.speed_reference = 16'(clamp_s16(round_q12(longint'(inv) * slew)));
        o.position_reference = 32'(round_q12(longint'(alpha) * held_pos +
                                             longint'(inv) * pos));
      end
    end
    o.blend_factor = alpha[12:0];
    o.lock_requested = lock_on;
    return o;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_refs.size() == 0) begin
      report_error("result with no item waiting for it");
      return;
    end
    want = expected_refs.pop_front();
    if (got.reference_valid !== want.reference_valid)
      report_error($sformatf("reference_valid got %0d want %0d",
                             got.reference_valid, want.reference_valid));
    if (got.position_reference !== want.position_reference)
      report_error($sformatf("position_reference got %0d want %0d",
                             $signed(got.position_reference), $signed(want.position_reference)));
    if (got.speed_reference !== want.speed_reference)
      report_error($sformatf("speed_reference got %0d want %0d",
                             $signed(got.speed_reference), $signed(want.speed_reference)));
    if (got.speed_reference_valid !== want.speed_reference_valid)
      report_error($sformatf("speed_reference_valid got %0d want %0d",
                             got.speed_reference_valid, want.speed_reference_valid));
    if (got.blend_factor !== want.blend_factor)
      report_error($sformatf("blend_factor got %0d want %0d",
                             got.blend_factor, want.blend_factor));
    if (got.lock_requested !== want.lock_requested)
      report_error($sformatf("lock_requested got %0d want %0d",
                             got.lock_requested, want.lock_requested));
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
  end

  // idle length: mostly short, now and then long
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall, with a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
      stall_left <= 0;
    end else if (hold_req || hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_req ? HOLD_CYCLES - 1 : hold_left - 1;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      result_stall <= 1'b1;
      stall_left <= idle_length() - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // offer one item, wait for acceptance and queue its expectation
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 99) < 25) gap = idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    expected_refs.push_back(predict_reference(it));
  endtask

  task automatic stop_items();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_refs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after the last one
  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPEED_DEADBAND:     settings.speed_deadband = value[11:0];
      REG_LOCK_ENTER_SPEED:   settings.lock_enter_speed = value[14:0];
      REG_LOCK_EXIT_SPEED:    settings.lock_exit_speed = value[14:0];
      REG_LOCK_ENTER_COMMAND: settings.lock_enter_command = value[14:0];
      REG_LOCK_EXIT_COMMAND:  settings.lock_exit_command = value[14:0];
      REG_MIN_DWELL_TICKS:    settings.min_dwell_ticks = value;
      REG_BLEND_RISE_STEP:    settings.blend_rise_step = value[12:0];
      REG_BLEND_FALL_STEP:    settings.blend_fall_step = value[12:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_regs_t s);
    write_register(REG_SPEED_DEADBAND, 16'(s.speed_deadband));
    write_register(REG_LOCK_ENTER_SPEED, 16'(s.lock_enter_speed));
    write_register(REG_LOCK_EXIT_SPEED, 16'(s.lock_exit_speed));
    write_register(REG_LOCK_ENTER_COMMAND, 16'(s.lock_enter_command));
    write_register(REG_LOCK_EXIT_COMMAND, 16'(s.lock_exit_command));
    write_register(REG_MIN_DWELL_TICKS, s.min_dwell_ticks);
    write_register(REG_BLEND_RISE_STEP, 16'(s.blend_rise_step));
    write_register(REG_BLEND_FALL_STEP, 16'(s.blend_fall_step));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_regs_t random_settings();
    cfg_regs_t s;
    s.speed_deadband = 12'($urandom_range(0, 4095));
    s.lock_enter_speed = 15'($urandom_range(0, 32767));
    s.lock_exit_speed = 15'($urandom_range(0, 32767));
    s.lock_enter_command = 15'($urandom_range(0, 32767));
    s.lock_exit_command = 15'($urandom_range(0, 32767));
    s.min_dwell_ticks = 16'($urandom_range(0, 300));
    s.blend_rise_step = 13'($urandom_range(0, 4096));
    s.blend_fall_step = 13'($urandom_range(0, 4096));
    return s;
  endfunction

  function automatic in_item_t make_item(logic [2:0] mode, bit mv, bit run, bit link,
                                         int cmd, int yaw, int pos, int spd,
                                         logic [31:0] tick);
    in_item_t it;
    it.mode = mode;
    it.mode_valid = mv;
    it.run_enable = run;
    it.link_ok = link;
    it.speed_command = cmd[15:0];
    it.yaw_command = yaw[23:0];
    it.measured_position = pos;
    it.measured_speed = spd[15:0];
    it.tick_now = tick;
    return it;
  endfunction

  // mostly coherent control ticks in one mode, with some raw noise
  function automatic in_item_t next_random_item();
    in_item_t    it;
    logic [127:0] raw;
    int          r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 99) < 12) begin
      it = raw[$bits(in_item_t)-1:0];
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 2) seq_mode = 3'($urandom_range(0, 7));
    else if (r < 5) seq_mode = 3'($urandom_range(MODE_LOW, MODE_HIGH));
    if ($urandom_range(0, 99) < 10) calm = !calm;
    cur_tick += ($urandom_range(0, 99) < 10) ? $urandom_range(100, 400) : $urandom_range(1, 40);
    cur_pos += int'($urandom_range(0, 4000)) - 2000;

    it.mode = seq_mode;
    it.mode_valid = $urandom_range(0, 99) < 98;
    it.run_enable = $urandom_range(0, 99) < 96;
    it.link_ok = $urandom_range(0, 99) < 95;
    if (calm) begin
      it.measured_speed = 16'(int'($urandom_range(0, 2800)) - 1400);
      it.speed_command = ($urandom_range(0, 1) == 0) ? 16'sd0 :
                         16'(int'($urandom_range(0, 1000)) - 500);
    end else begin
      it.measured_speed = ($urandom_range(0, 1) == 0) ? raw[15:0] :
                          16'(int'($urandom_range(0, 12000)) - 6000);
      it.speed_command = raw[31:16];
    end
    it.yaw_command = ($urandom_range(0, 1) == 0) ? raw[55:32] :
                     24'(int'($urandom_range(0, 1400000)) - 700000);
    it.measured_position = ($urandom_range(0, 99) < 5) ? raw[95:64] : cur_pos;
    it.tick_now = cur_tick;
    return it;
  endfunction

  // fixed ticks through every mode and the corner cases
  task automatic test_directed_cases();
    // mode not yet valid, then no force with run off and field maxima
    send_item(make_item(MODE_MID, 0, 1, 1, 100, 0, 1234, 50, 32'd1000));
    send_item(make_item(MODE_NO_FORCE, 1, 0, 1, 32767, 0, 32'h7fffffff, 32767, 32'd1010));
    // spin with field minima
    send_item(make_item(MODE_SPIN, 1, 1, 1, -32768, 0, 32'h80000000, -32768, 32'd1020));
    // mode change while not permitted, then link down
    send_item(make_item(MODE_LOW, 1, 0, 1, 0, 0, 5000, 300, 32'd1030));
    send_item(make_item(MODE_LOW, 1, 1, 0, 200, 0, 5100, 300, 32'd1040));
    // standstill locks once the dwell has passed, alpha ramps
    send_item(make_item(MODE_LOW, 1, 1, 1, 0, 0, 6000, 0, 32'd1200));
    send_item(make_item(MODE_LOW, 1, 1, 1, 100, 0, 6100, 20, 32'd1210));
    send_item(make_item(MODE_LOW, 1, 1, 1, 100, 0, 6200, -20, 32'd1220));
    send_item(make_item(MODE_LOW, 1, 1, 1, -100, 0, 6300, 20, 32'd1230));
    // full stick: unlock and gain saturation
    send_item(make_item(MODE_LOW, 1, 1, 1, 32767, 0, 7000, 100, 32'd1400));
    // most negative stick with yaw at pi: negation saturates
    send_item(make_item(MODE_LOW, 1, 1, 1, -32768, 205887, 7100, 100, 32'd1410));
    send_item(make_item(MODE_LOW, 1, 1, 1, 20000, 8388607, 7200, 100, 32'd1420));
    send_item(make_item(MODE_LOW, 1, 1, 1, -20000, -8388608, 7300, 100, 32'd1430));
    // tick counter wraps between switches
    send_item(make_item(MODE_LOW, 1, 1, 1, 0, -617661, 7400, 0, 32'hfffffff0));
    send_item(make_item(MODE_LOW, 1, 1, 1, 0, 0, 7500, 0, 32'h00000060));
    // mid leg, just under the lock thresholds
    send_item(make_item(MODE_MID, 1, 1, 1, 300, 0, 8000, 1228, 32'h00000100));
    send_item(make_item(MODE_MID, 1, 1, 1, 327, 0, 8100, -1228, 32'h00000200));
    // high leg
    send_item(make_item(MODE_HIGH, 1, 1, 1, 5000, 0, 8200, -2000, 32'h00000300));
    send_item(make_item(MODE_HIGH, 1, 1, 1, 5000, 0, 8300, -2000, 32'h00000310));
    // jump phases
    send_item(make_item(MODE_RETRACT1, 1, 1, 1, 1000, 0, 8400, 0, 32'h00000400));
    send_item(make_item(MODE_EXTEND, 1, 1, 1, -1000, 205887, 8500, 0, 32'h00000500));
    send_item(make_item(MODE_RETRACT2, 1, 1, 1, 1000, 0, 8600, 0, 32'h00000600));
    // link down in no force, spin with run off
    send_item(make_item(MODE_NO_FORCE, 1, 1, 0, 0, 0, 8700, 500, 32'h00000700));
    send_item(make_item(MODE_SPIN, 1, 0, 1, 0, 0, 8800, 500, 32'h00000800));
    stop_items();
    wait_results_drained();
  endtask

  // random ticks under several register settings, extremes included
  task automatic test_register_sweep();
    cfg_regs_t sets[5];
    sets[0] = '0;
    sets[1] = cfg_regs_t'{12'd4095, 15'd32767, 15'd32767, 15'd32767, 15'd32767,
                          16'd65535, 13'd4096, 13'd4096};
    sets[2] = cfg_regs_t'{12'd200, 15'd3000, 15'd500, 15'd2000, 15'd100,
                          16'd0, 13'd4096, 13'd4096};
    sets[3] = random_settings();
    sets[4] = random_settings();
    foreach (sets[s]) begin
      wait_results_drained();
      apply_settings(sets[s]);
      repeat (55) send_item(next_random_item());
      stop_items();
    end
    wait_results_drained();
  endtask

  // random ticks with lively locking, then a stretch without idling
  task automatic test_random_traffic();
    apply_settings(cfg_regs_t'{12'd410, 15'd2000, 15'd3000, 15'd600, 15'd900,
                               16'd20, 13'd300, 13'd200});
    repeat (70) send_item(next_random_item());
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (30) send_item(next_random_item());
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    stop_items();
    wait_results_drained();
  endtask

  // receiver holds off while items keep coming, then sender waits it out
  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (40) send_item(next_random_item());
    tx_calm = 1'b0;
    stop_items();
    wait_results_drained();
    repeat (10) send_item(next_random_item());
    stop_items();
    wait_results_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_sweep();
    test_random_traffic();
    test_backpressure();
    if (error_count == 0 && expected_refs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
